/* rtl/etdmx_pkg.sv */
// Shared types and constants for the ethertype demux table.
// Used by etdmx_ctrl, etdmx_dpath and ethertype_demux_table_unit.
`default_nettype none

package etdmx_pkg;

	// stream payload widths
	localparam int S_TDATA_W = 56;  // family, ethertype, desc_length
	localparam int S_TUSER_W = 3;   // op, desc_is_etype2
	localparam int M_TDATA_W = 32;  // found_family
	localparam int M_TUSER_W = 3;   // status

	localparam logic [7:0] DESC_LEN_REQ = 8'd2;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_DEL    = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_LENGTH  = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_FULL        = 3'd3,
		ST_NO_MATCH    = 3'd4,
		ST_EMPTY       = 3'd5
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_item;
		logic    clr;
		logic    scan_step;
		logic    add_commit;
		logic    walk_issue;
		logic    cmp_del;
		logic    cmp_lookup;
		logic    del_finish;
		logic    out_load;
		logic    out_found;
		status_t out_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic is_e2;
		logic len_ok;
		logic used_zero;
		logic full;
		logic slot_free;
		logic idx_at_hw;
		logic s1_vld;
		logic lk_match;
		logic del_hit;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/etdmx_dpath.sv */
// Datapath of the ethertype demux table: item registers, table memory,
// valid bits, counters, walk pipeline and result register. Uses etdmx_pkg.
`default_nettype none

module etdmx_dpath #(
	parameter int ENTRIES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [etdmx_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [etdmx_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire etdmx_pkg::cmd_t                 cmd,
	output etdmx_pkg::stat_t                     st,
	output logic      [etdmx_pkg::M_TDATA_W-1:0] m_tdata,
	output logic      [etdmx_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// item registers
	etdmx_pkg::op_t op_q;
	logic [31:0]    fam_q;
	logic [15:0]    et_q;
	logic           e2_q;
	logic [7:0]     len_q;

	// table
	logic [31:0]        fam_mem [ENTRIES];
	logic [15:0]        et_mem  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      used_q;
	logic [CW-1:0]      hw_q;
	logic [CW-1:0]      idx_q;

	// walk pipeline
	logic          rd_vld_s1;
	logic          rd_ok_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [31:0]   rd_fam_s1;
	logic [15:0]   rd_et_s1;

	logic          hit_q;
	logic          keep_q;
	logic [AW-1:0] keep_idx_q;
	logic [31:0]   found_q;

	logic [31:0]   out_fam_q;
	logic [2:0]    out_status_q;

	logic          del_match;
	logic          lk_match;
	logic          entry_live;
	logic [CW-1:0] idx_inc;

	assign entry_live = rd_vld_s1 & rd_ok_s1;
	assign del_match  = entry_live & (rd_fam_s1 == fam_q);
	assign lk_match   = entry_live & (rd_et_s1 == et_q);
	assign idx_inc    = idx_q + CW'(1);

	always_comb begin
		st.op        = op_q;
		st.is_e2     = e2_q;
		st.len_ok    = (len_q == etdmx_pkg::DESC_LEN_REQ);
		st.used_zero = (used_q == '0);
		st.full      = (used_q == CW'(ENTRIES));
		st.slot_free = ~valid_q[idx_q[AW-1:0]];
		st.idx_at_hw = (idx_q == hw_q);
		st.s1_vld    = rd_vld_s1;
		st.lk_match  = lk_match;
		st.del_hit   = hit_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= etdmx_pkg::op_t'(s_tuser[1:0]);
			e2_q  <= s_tuser[2];
			fam_q <= s_tdata[31:0];
			et_q  <= s_tdata[47:32];
			len_q <= s_tdata[55:48];
		end
		if (cmd.add_commit) begin
			fam_mem[idx_q[AW-1:0]] <= fam_q;
			et_mem[idx_q[AW-1:0]]  <= et_q;
		end
		if (cmd.walk_issue) begin
			rd_fam_s1 <= fam_mem[idx_q[AW-1:0]];
			rd_et_s1  <= et_mem[idx_q[AW-1:0]];
			rd_ok_s1  <= valid_q[idx_q[AW-1:0]];
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.cmp_lookup && lk_match) begin
			found_q <= rd_fam_s1;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_fam_q    <= cmd.out_found ? found_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			used_q     <= '0;
			hw_q       <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			keep_q     <= 1'b0;
			keep_idx_q <= '0;
		end else begin
			rd_vld_s1 <= cmd.walk_issue;
			if (cmd.clr) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				keep_q <= 1'b0;
			end else if (cmd.scan_step || cmd.walk_issue) begin
				idx_q <= idx_inc;
			end
			if (cmd.add_commit) begin
				valid_q[idx_q[AW-1:0]] <= 1'b1;
				used_q                 <= used_q + CW'(1);
				if (idx_inc > hw_q) begin
					hw_q <= idx_inc;
				end
			end
			if (cmd.cmp_del) begin
				if (del_match) begin
					valid_q[rd_idx_s1] <= 1'b0;
					used_q             <= used_q - CW'(1);
					hit_q              <= 1'b1;
				end else if (entry_live) begin
					// walk ascends, so the last kept entry is the highest one
					keep_q     <= 1'b1;
					keep_idx_q <= rd_idx_s1;
				end
			end
			if (cmd.del_finish && hit_q) begin
				hw_q <= keep_q ? (CW'(keep_idx_q) + CW'(1)) : '0;
			end
		end
	end

	assign m_tdata = out_fam_q;
	assign m_tuser = out_status_q;

endmodule

`default_nettype wire

/* rtl/etdmx_ctrl.sv */
// Controller of the ethertype demux table: sequences checks, free-slot
// scan, table walk and result handoff. Uses etdmx_pkg.
`default_nettype none

module etdmx_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire etdmx_pkg::stat_t st,
	output etdmx_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WALK,
		S_DONE
	} state_t;

	state_t                  state_q, state_d;
	etdmx_pkg::status_t      res_q, res_d;
	logic                    fnd_q, fnd_d;
	logic                    out_vld_q, out_vld_d;
	logic                    walk_end;

	// nothing in flight and nothing left to issue
	assign walk_end = st.idx_at_hw & ~st.s1_vld;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		res_d   = res_q;
		fnd_d   = fnd_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.clr = 1'b1;
				fnd_d   = 1'b0;
				state_d = S_DONE;
				case (st.op)
					etdmx_pkg::OP_ADD: begin
						if (!st.is_e2) begin
							res_d = etdmx_pkg::ST_UNSUPPORTED;
						end else if (!st.len_ok) begin
							res_d = etdmx_pkg::ST_BAD_LENGTH;
						end else if (st.full) begin
							res_d = etdmx_pkg::ST_FULL;
						end else begin
							state_d = S_SCAN;
						end
					end
					etdmx_pkg::OP_DEL, etdmx_pkg::OP_LOOKUP: begin
						if (st.used_zero) begin
							res_d = etdmx_pkg::ST_EMPTY;
						end else begin
							state_d = S_WALK;
						end
					end
					default: begin
						res_d = etdmx_pkg::ST_UNSUPPORTED;
					end
				endcase
			end
			S_SCAN: begin
				// a free slot exists since the table is not full
				if (st.slot_free) begin
					cmd.add_commit = 1'b1;
					res_d          = etdmx_pkg::ST_OK;
					state_d        = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_WALK: begin
				cmd.walk_issue = ~st.idx_at_hw;
				if (st.op == etdmx_pkg::OP_LOOKUP) begin
					cmd.cmp_lookup = 1'b1;
					if (st.lk_match) begin
						res_d   = etdmx_pkg::ST_OK;
						fnd_d   = 1'b1;
						state_d = S_DONE;
					end else if (walk_end) begin
						res_d   = etdmx_pkg::ST_NO_MATCH;
						state_d = S_DONE;
					end
				end else begin
					cmd.cmp_del = 1'b1;
					if (walk_end) begin
						cmd.del_finish = 1'b1;
						res_d   = st.del_hit ? etdmx_pkg::ST_OK : etdmx_pkg::ST_NO_MATCH;
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.out_status = res_q;
		cmd.out_found  = fnd_q;

		if (cmd.out_load) begin
			out_vld_d = 1'b1;
		end else if (m_tready) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_q     <= etdmx_pkg::ST_OK;
			fnd_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_q     <= res_d;
			fnd_q     <= fnd_d;
			out_vld_q <= out_vld_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_vld_q;

endmodule

`default_nettype wire

/* rtl/ethertype_demux_table_unit.sv */
// Top level of the ethertype demux table: controller plus datapath.
// Depends on etdmx_pkg, etdmx_ctrl and etdmx_dpath.
//
//   channel | dir | tdata (low bit up)                     | tuser (low bit up)
//   s_*     | in  | family 32, ethertype 16, desc_length 8 | op 2, desc_is_etype2 1
//   m_*     | out | found_family 32                        | status 3
//
// One transaction at a time. Rejected adds, empty-table and unknown ops end
// after the check; an add first scans for the lowest free slot; delete and
// lookup walk the table one entry per cycle through a registered memory read,
// up to the high-water mark (a lookup hit ends the walk at its slot).
// A finished result sits in the output register while the next transaction is
// taken; the block only stalls when that register is still full at finish.
// Reset clears valid bits, counts and the handshake state; no clearing pass.
`default_nettype none

module ethertype_demux_table_unit #(
	parameter int ENTRIES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// family[31:0], ethertype[47:32], desc_length[55:48]
	input  wire logic [etdmx_pkg::S_TDATA_W-1:0] s_tdata,
	// op[1:0], desc_is_etype2[2]
	input  wire logic [etdmx_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// found_family[31:0]
	output logic      [etdmx_pkg::M_TDATA_W-1:0] m_tdata,
	// status[2:0]
	output logic      [etdmx_pkg::M_TUSER_W-1:0] m_tuser
);

	etdmx_pkg::cmd_t  cmd;
	etdmx_pkg::stat_t st;

	etdmx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	etdmx_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.st      (st),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

`default_nettype wire
